// File: sv/spo2bp_pkg.sv
// Shared constants and widths of the oxygen-saturation baseline block.
package spo2bp_pkg;

    // Field widths.
    localparam int RAW_W   = 16;
    localparam int FV_W    = 17;
    localparam int ENTRY_W = 18;
    localparam int LEVEL_W = 14;
    localparam int CNT_W   = 11;
    localparam int SPE_W   = 6;
    localparam int CFG_D_W = 11;
    localparam int CFG_I_W = 2;

    // Default structure sizes.
    localparam int MEDIAN_LENGTH_DEF = 5;
    localparam int WINDOW_DEPTH_DEF  = 1024;
    localparam int EPOCH_MAX_DEF     = 32;

    // Register reset values.
    localparam logic [SPE_W-1:0]   SPE_RESET = SPE_W'(30);
    localparam logic [CFG_D_W-1:0] WIN_RESET = CFG_D_W'(600);

    // Register indexes.
    localparam logic [CFG_I_W-1:0] CFG_SAMPLES_PER_EPOCH = 2'd0;
    localparam logic [CFG_I_W-1:0] CFG_WINDOW_SAMPLES    = 2'd1;

    // Usable range in half-hundredths of a percent, and its offset width.
    localparam logic [FV_W-1:0] USABLE_LOW  = FV_W'(16000);
    localparam logic [FV_W-1:0] USABLE_HIGH = FV_W'(20000);
    localparam int OFS_W = 12;

    localparam int MIN_USABLE = 10;
    localparam logic [LEVEL_W-1:0] DEFAULT_LEVEL = LEVEL_W'(9600);

endpackage

// File: sv/spo2bp_ram.sv
// Generic single-write, single-read RAM with registered read data.
module spo2bp_ram #(
    parameter int WIDTH = 18,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: sv/spo2bp_median.sv
// Trailing median over the valid taps, in half-hundredths of a percent.
module spo2bp_median #(
    parameter int MEDIAN_LENGTH = spo2bp_pkg::MEDIAN_LENGTH_DEF
) (
    input  logic [spo2bp_pkg::RAW_W-1:0] i_taps [MEDIAN_LENGTH],
    input  logic [MEDIAN_LENGTH-1:0]     i_ok,
    output logic [spo2bp_pkg::FV_W-1:0]  o_value
);
    import spo2bp_pkg::*;

    localparam int RW = $clog2(MEDIAN_LENGTH + 1);

    logic [RW-1:0]    rank [MEDIAN_LENGTH];
    logic [RW-1:0]    n_ok;
    logic [RW-1:0]    a_rank;
    logic [RW-1:0]    b_rank;
    logic [RAW_W-1:0] va;
    logic [RAW_W-1:0] vb;

    // Each valid tap gets a unique rank; ties break by tap position.
    always_comb begin
        n_ok = '0;
        for (int j = 0; j < MEDIAN_LENGTH; j++) begin
            n_ok = n_ok + RW'(i_ok[j]);
        end
        for (int i = 0; i < MEDIAN_LENGTH; i++) begin
            rank[i] = '0;
            for (int j = 0; j < MEDIAN_LENGTH; j++) begin
                if (j != i && i_ok[j] &&
                    (i_taps[j] < i_taps[i] || (i_taps[j] == i_taps[i] && j < i))) begin
                    rank[i] = rank[i] + RW'(1);
                end
            end
        end
        a_rank = n_ok >> 1;
        b_rank = n_ok[0] ? a_rank : a_rank - RW'(1);
        va = '0;
        vb = '0;
        for (int i = 0; i < MEDIAN_LENGTH; i++) begin
            if (i_ok[i] && rank[i] == a_rank) begin
                va = i_taps[i];
            end
            if (i_ok[i] && rank[i] == b_rank) begin
                vb = i_taps[i];
            end
        end
        // An odd count picks the same tap twice, which doubles it.
        o_value = (n_ok == '0) ? '0 : FV_W'(va) + FV_W'(vb);
    end

endmodule

// File: sv/spo2_baseline_percentile.sv
// Rolling 90th-percentile oxygen-saturation baseline over a sliding window.
// A sample that ends no epoch passes through the filter state and back to idle. An epoch end
// walks the window store in 14 passes of take = min(filled, window) entries each, through the
// one read port, with the division states after the first pass and the level states after the last.
// An epoch with fewer than ten usable entries stops after the first pass.
// Throughput: one sample at a time; the next sample is taken while a result waits.
// Reset (synchronous, active low) clears control state; the window store is not cleared.
module spo2_baseline_percentile #(
    parameter int MEDIAN_LENGTH = spo2bp_pkg::MEDIAN_LENGTH_DEF,
    parameter int WINDOW_DEPTH  = spo2bp_pkg::WINDOW_DEPTH_DEF,
    parameter int EPOCH_MAX     = spo2bp_pkg::EPOCH_MAX_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // Sample channel.
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [spo2bp_pkg::RAW_W-1:0]   i_raw_saturation,
    input  logic                           i_sample_valid,
    // Result channel.
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [spo2bp_pkg::LEVEL_W-1:0] o_baseline_level,
    output logic [spo2bp_pkg::CNT_W-1:0]   o_usable_count,
    output logic                           o_used_default,
    // Configuration write channel.
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [spo2bp_pkg::CFG_I_W-1:0] i_cfg_index,
    input  logic [spo2bp_pkg::CFG_D_W-1:0] i_cfg_data
);
    import spo2bp_pkg::*;

    localparam int AW = $clog2(WINDOW_DEPTH);
    localparam int CW = $clog2(WINDOW_DEPTH + 1);
    localparam int EW = $clog2(EPOCH_MAX + 1);
    localparam int MW = CW + 4;
    localparam logic [3:0] PASS_COUNT = 4'd0;
    localparam logic [3:0] PASS_FINAL = 4'(OFS_W + 1);

    // A sample that ends no epoch visits only the idle and filter states; the scan state is reused
    // for every pass over the window store.
    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001,
        S_FILT = 9'b000000010,
        S_SCAN = 9'b000000100,
        S_DIV1 = 9'b000001000,
        S_DIV2 = 9'b000010000,
        S_LVL1 = 9'b000100000,
        S_LVL2 = 9'b001000000,
        S_LVL3 = 9'b010000000,
        S_FIN  = 9'b100000000
    } t_state;

    t_state r_state;

    // Configuration registers.
    logic [SPE_W-1:0]   r_spe;
    logic [CFG_D_W-1:0] r_win;

    // Median taps: a short shift line of samples and their valid flags.
    logic [RAW_W-1:0]         r_taps [MEDIAN_LENGTH];
    logic [MEDIAN_LENGTH-1:0] r_tap_ok;
    logic [FV_W-1:0]          med_value;

    // Window bookkeeping.
    logic [AW-1:0] r_head;
    logic [CW-1:0] r_count;
    logic [EW-1:0] r_pos;
    logic [AW-1:0] r_rstart;

    // Scan engine.
    logic [AW-1:0]    r_rptr;
    logic [CW-1:0]    r_issue;
    logic [CW-1:0]    r_take;
    logic             r_pend;
    logic [3:0]       r_pass;
    logic [CW-1:0]    r_cnt;
    logic [OFS_W-1:0] r_min;
    logic [OFS_W-1:0] r_prefix;

    // Percentile arithmetic.
    logic [CW-1:0]      r_n;
    logic [MW-1:0]      r_m;
    logic [MW+12:0]     r_prod;
    logic [CW-1:0]      r_lo;
    logic [3:0]         r_fr;
    logic [OFS_W-1:0]   r_shi;
    logic [17:0]        r_big;
    logic [15:0]        r_x;
    logic [31:0]        r_px;
    logic [LEVEL_W-1:0] r_level;
    logic               r_dflt;

    // Output register.
    logic               r_out_valid;
    logic [LEVEL_W-1:0] r_out_level;
    logic [CNT_W-1:0]   r_out_count;
    logic               r_out_dflt;

    logic [ENTRY_W-1:0] ram_rdata;
    logic               ram_we;

    // Effective epoch and window lengths after clamping.
    logic [EW-1:0] spe_eff;
    logic [CW-1:0] wlen_eff;
    logic [EW-1:0] pos_inc;
    logic [CW-1:0] count_inc;
    logic [AW-1:0] head_inc;

    // Per-entry classification during a scan.
    logic [FV_W-1:0]  e_val;
    logic             e_usable;
    logic [OFS_W-1:0] e_ofs;
    logic [3:0]       bitpos;
    logic [OFS_W-1:0] thr;
    logic             e_hit;
    logic             e_lower_min;
    logic             issue_now;
    logic             pass_done;
    logic             out_free;

    // Division helpers.
    logic [MW-1:0]  q10;
    logic [MW-1:0]  rem10;
    logic [14:0]    slo_abs;
    logic [15:0]    x_val;
    logic [15:0]    q5;
    logic [15:0]    rem5;

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid      = r_out_valid;
    assign o_baseline_level = r_out_level;
    assign o_usable_count   = r_out_count;
    assign o_used_default   = r_out_dflt;

    spo2bp_median #(
        .MEDIAN_LENGTH(MEDIAN_LENGTH)
    ) u_median (
        .i_taps (r_taps),
        .i_ok   (r_tap_ok),
        .o_value(med_value)
    );

    assign ram_we = (r_state == S_FILT);

    spo2bp_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(WINDOW_DEPTH)
    ) u_window (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(r_head),
        .i_wdata({r_tap_ok[0], med_value}),
        .i_raddr(r_rptr),
        .o_rdata(ram_rdata)
    );

    always_comb begin
        // A zero length counts as one; lengths beyond the built size saturate.
        if (r_spe == '0) begin
            spe_eff = EW'(1);
        end else if (32'(r_spe) > EPOCH_MAX) begin
            spe_eff = EW'(EPOCH_MAX);
        end else begin
            spe_eff = EW'(r_spe);
        end
        if (r_win == '0) begin
            wlen_eff = CW'(1);
        end else if (32'(r_win) > WINDOW_DEPTH) begin
            wlen_eff = CW'(WINDOW_DEPTH);
        end else begin
            wlen_eff = CW'(r_win);
        end
        pos_inc   = r_pos + EW'(1);
        count_inc = (r_count == CW'(WINDOW_DEPTH)) ? r_count : r_count + CW'(1);
        head_inc  = (r_head == AW'(WINDOW_DEPTH - 1)) ? '0 : r_head + AW'(1);
    end

    always_comb begin
        e_val    = ram_rdata[FV_W-1:0];
        e_usable = ram_rdata[ENTRY_W-1] && (e_val >= USABLE_LOW) && (e_val <= USABLE_HIGH);
        e_ofs    = OFS_W'(e_val - USABLE_LOW);
        bitpos   = 4'(OFS_W) - r_pass;
        thr      = r_prefix | ((OFS_W'(1) << bitpos) - OFS_W'(1));
        if (r_pass == PASS_COUNT) begin
            e_hit = e_usable;
        end else if (r_pass == PASS_FINAL) begin
            e_hit = e_usable && (e_ofs <= r_prefix);
        end else begin
            e_hit = e_usable && (e_ofs <= thr);
        end
        e_lower_min = (r_pass == PASS_FINAL) && e_usable && (e_ofs > r_prefix) &&
                      (e_ofs < r_min);
        issue_now = (r_state == S_SCAN) && (r_issue < r_take);
        pass_done = (r_state == S_SCAN) && (r_issue == r_take) && !r_pend;
        out_free  = !r_out_valid || !i_out_stall;
    end

    always_comb begin
        // Quotient by ten from an underestimating reciprocal, then one correction.
        q10   = MW'(r_prod >> 16);
        rem10 = r_m - MW'(q10 * MW'(10));
        if (rem10 >= MW'(10)) begin
            q10   = q10 + MW'(1);
            rem10 = rem10 - MW'(10);
        end
        slo_abs = 15'(r_prefix) + 15'(USABLE_LOW);
        x_val   = 16'((r_big + 18'd10) >> 2);
        q5      = r_px[31:16];
        rem5    = r_x - 16'(q5 * 16'd5);
        if (rem5 >= 16'd5) begin
            q5 = q5 + 16'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_spe       <= SPE_RESET;
            r_win       <= WIN_RESET;
            r_tap_ok    <= '0;
            r_head      <= '0;
            r_count     <= '0;
            r_pos       <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_SAMPLES_PER_EPOCH: r_spe <= SPE_W'(i_cfg_data);
                    CFG_WINDOW_SAMPLES:    r_win <= i_cfg_data;
                    default: ;
                endcase
            end

            // The finish state refills the output register itself.
            if (r_out_valid && !i_out_stall && r_state != S_FIN) begin
                r_out_valid <= 1'b0;
            end

            r_pend <= issue_now;

            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_tap_ok <= {r_tap_ok[MEDIAN_LENGTH-2:0], i_sample_valid};
                        r_state  <= S_FILT;
                    end
                end
                S_FILT: begin
                    // The filtered word goes into the window; an epoch end starts a scan
                    // from the entry just written, back toward older entries.
                    r_head   <= head_inc;
                    r_count  <= count_inc;
                    r_rstart <= r_head;
                    r_rptr   <= r_head;
                    if (pos_inc >= spe_eff) begin
                        r_pos   <= '0;
                        r_take  <= (count_inc < wlen_eff) ? count_inc : wlen_eff;
                        r_issue <= '0;
                        r_cnt   <= '0;
                        r_pass  <= PASS_COUNT;
                        r_state <= S_SCAN;
                    end else begin
                        r_pos   <= pos_inc;
                        r_state <= S_IDLE;
                    end
                end
                S_SCAN: begin
                    if (issue_now) begin
                        r_issue <= r_issue + CW'(1);
                        r_rptr  <= (r_rptr == '0) ? AW'(WINDOW_DEPTH - 1) : r_rptr - AW'(1);
                    end
                    if (r_pend) begin
                        if (e_hit) begin
                            r_cnt <= r_cnt + CW'(1);
                        end
                        if (e_lower_min) begin
                            r_min <= e_ofs;
                        end
                    end
                    if (pass_done) begin
                        r_issue <= '0;
                        r_cnt   <= '0;
                        r_rptr  <= r_rstart;
                        if (r_pass == PASS_COUNT) begin
                            r_n <= r_cnt;
                            if (r_cnt < CW'(MIN_USABLE)) begin
                                r_level <= DEFAULT_LEVEL;
                                r_dflt  <= 1'b1;
                                r_state <= S_FIN;
                            end else begin
                                r_m     <= MW'(r_cnt - CW'(1)) * MW'(9);
                                r_state <= S_DIV1;
                            end
                        end else if (r_pass == PASS_FINAL) begin
                            // The next sorted value equals this one when enough entries tie.
                            r_shi   <= ({1'b0, r_cnt} >= {1'b0, r_lo} + (CW + 1)'(2)) ?
                                       r_prefix : r_min;
                            r_state <= S_LVL1;
                        end else begin
                            // Radix select: the bit is one when too few entries lie below.
                            if (r_cnt <= r_lo) begin
                                r_prefix <= r_prefix | (OFS_W'(1) << bitpos);
                            end
                            r_pass <= r_pass + 4'd1;
                            r_min  <= '1;
                        end
                    end
                end
                S_DIV1: begin
                    r_prod  <= (MW + 13)'(r_m) * (MW + 13)'(6553);
                    r_state <= S_DIV2;
                end
                S_DIV2: begin
                    r_lo     <= CW'(q10);
                    r_fr     <= 4'(rem10);
                    r_prefix <= '0;
                    r_pass   <= PASS_COUNT + 4'd1;
                    r_state  <= S_SCAN;
                end
                S_LVL1: begin
                    r_big   <= 18'(slo_abs) * 18'd10 + 18'(r_fr) * 18'(r_shi - r_prefix);
                    r_state <= S_LVL2;
                end
                S_LVL2: begin
                    r_x     <= x_val;
                    r_px    <= 32'(x_val) * 32'd13107;
                    r_state <= S_LVL3;
                end
                S_LVL3: begin
                    r_level <= LEVEL_W'(q5);
                    r_dflt  <= 1'b0;
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Payload registers without reset.
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_in_valid) begin
            r_taps[0] <= i_raw_saturation;
            for (int i = 1; i < MEDIAN_LENGTH; i++) begin
                r_taps[i] <= r_taps[i-1];
            end
        end
        if (r_state == S_FIN && out_free) begin
            r_out_level <= r_level;
            r_out_count <= CNT_W'(r_n);
            r_out_dflt  <= r_dflt;
        end
    end

`ifndef SYNTHESIS
    a_issue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_issue <= r_take))
        else $error("scan issued past the window length");
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(WINDOW_DEPTH))
        else $error("window fill count overflow");
    a_accept_filt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> (r_state == S_FILT))
        else $error("accepted word not filtered next cycle");
    a_default_few: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_used_default) |-> (o_usable_count < CNT_W'(MIN_USABLE)))
        else $error("default given with enough usable entries");
    a_level_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_used_default) |->
            (o_baseline_level >= LEVEL_W'(8000) && o_baseline_level <= LEVEL_W'(10000)))
        else $error("percentile outside usable range");
`endif

endmodule

// File: dv/spo2_baseline_percentile_test.sv
// Testbench for the rolling 90th-percentile oxygen-saturation baseline block.
`timescale 1ns / 1ps

module spo2_baseline_percentile_test;
    import spo2bp_pkg::*;

    // Register indexes that the block does not decode; writes to them are dropped.
    localparam logic [CFG_I_W-1:0] CFG_UNUSED_A = 2'd2;
    localparam logic [CFG_I_W-1:0] CFG_UNUSED_B = 2'd3;
    localparam int DEPTH       = WINDOW_DEPTH_DEF;
    localparam int TAPS        = MEDIAN_LENGTH_DEF;
    localparam int CYCLE_LIMIT = 4000000;

    // One baseline word as it leaves the block.
    typedef struct {
        logic [LEVEL_W-1:0] level;
        logic [CNT_W-1:0]   count;
        logic               dflt;
    } t_baseline;

    // Scoreboard: mirrors the median filter, the window store and the epoch
    // counter, and keeps the baselines that are still owed by the block.
    class t_baseline_board;
        t_baseline        owed[$];
        int               errors;
        int               checked;
        logic [SPE_W-1:0] spe_reg;
        logic [CFG_D_W-1:0] win_reg;
        logic [RAW_W-1:0] taps[TAPS];
        logic             tap_ok[TAPS];
        int               fill;
        logic [ENTRY_W-1:0] store[DEPTH];
        int               head;
        int               count;
        int               epoch_pos;
        int unsigned      work[DEPTH];

        function new();
            spe_reg = SPE_RESET;
            win_reg = WIN_RESET;
            for (int i = 0; i < TAPS; i++) begin
                taps[i] = '0;
                tap_ok[i] = 1'b0;
            end
            fill = 0;
            head = 0;
            count = 0;
            epoch_pos = 0;
            errors = 0;
            checked = 0;
        endfunction

        function void write_reg(logic [CFG_I_W-1:0] idx, logic [CFG_D_W-1:0] data);
            if (idx == CFG_SAMPLES_PER_EPOCH) spe_reg = data[SPE_W-1:0];
            else if (idx == CFG_WINDOW_SAMPLES) win_reg = data;
        endfunction

        function void sort_work(int n);
            int unsigned v;
            int j;
            for (int i = 1; i < n; i++) begin
                v = work[i];
                j = i;
                while (j > 0 && work[j-1] > v) begin
                    work[j] = work[j-1];
                    j--;
                end
                work[j] = v;
            end
        endfunction

        // Runs one accepted sample through the mirror and queues a baseline
        // when it closes an epoch.
        function void note_sample(logic [RAW_W-1:0] raw, logic ok);
            int n;
            int spe;
            int wlen;
            int take;
            int lo;
            int fr;
            int idx;
            longint unsigned big;
            logic [FV_W-1:0] fv;
            t_baseline b;
            for (int i = TAPS - 1; i > 0; i--) begin
                taps[i] = taps[i-1];
                tap_ok[i] = tap_ok[i-1];
            end
            taps[0] = raw;
            tap_ok[0] = ok;
            if (fill < TAPS) fill++;

            // Median of the valid taps in half-hundredths; even counts average.
            n = 0;
            for (int i = 0; i < fill; i++) begin
                if (tap_ok[i]) begin
                    work[n] = taps[i];
                    n++;
                end
            end
            if (n == 0) begin
                fv = '0;
            end else begin
                sort_work(n);
                if (n % 2 == 1) fv = FV_W'(2 * work[n/2]);
                else fv = FV_W'(work[n/2-1] + work[n/2]);
            end
            store[head] = {ok, fv};
            head = (head + 1) % DEPTH;
            if (count < DEPTH) count++;

            spe = spe_reg;
            if (spe == 0) spe = 1;
            if (spe > EPOCH_MAX_DEF) spe = EPOCH_MAX_DEF;
            epoch_pos++;
            if (epoch_pos < spe) return;
            epoch_pos = 0;

            wlen = win_reg;
            if (wlen == 0) wlen = 1;
            if (wlen > DEPTH) wlen = DEPTH;
            take = (count < wlen) ? count : wlen;
            n = 0;
            for (int i = 0; i < take; i++) begin
                idx = (head + DEPTH - 1 - i) % DEPTH;
                if (store[idx][ENTRY_W-1] && store[idx][FV_W-1:0] >= USABLE_LOW &&
                        store[idx][FV_W-1:0] <= USABLE_HIGH) begin
                    work[n] = store[idx][FV_W-1:0];
                    n++;
                end
            end
            if (n >= MIN_USABLE) begin
                sort_work(n);
                lo = (9 * (n - 1)) / 10;
                fr = (9 * (n - 1)) % 10;
                big = 10 * longint'(work[lo]);
                if (fr != 0) big += fr * longint'(work[lo+1] - work[lo]);
                b.level = LEVEL_W'((big + 10) / 20);
                b.dflt = 1'b0;
            end else begin
                b.level = DEFAULT_LEVEL;
                b.dflt = 1'b1;
            end
            b.count = CNT_W'(n);
            owed.push_back(b);
        endfunction

        function void check_result(t_baseline got);
            t_baseline exp_b;
            if (owed.size() == 0) begin
                $error("baseline word with none owed: level %0d", got.level);
                errors++;
                return;
            end
            exp_b = owed.pop_front();
            checked++;
            if (got.level !== exp_b.level) begin
                $error("baseline_level: expected %0d, got %0d", exp_b.level, got.level);
                errors++;
            end
            if (got.count !== exp_b.count) begin
                $error("usable_count: expected %0d, got %0d", exp_b.count, got.count);
                errors++;
            end
            if (got.dflt !== exp_b.dflt) begin
                $error("used_default: expected %0d, got %0d", exp_b.dflt, got.dflt);
                errors++;
            end
        endfunction
    endclass

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_stall;
    logic [RAW_W-1:0]   i_raw_saturation = '0;
    logic               i_sample_valid = 1'b0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    logic [LEVEL_W-1:0] o_baseline_level;
    logic [CNT_W-1:0]   o_usable_count;
    logic               o_used_default;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic [CFG_I_W-1:0] i_cfg_index = '0;
    logic [CFG_D_W-1:0] i_cfg_data = '0;

    t_baseline_board board = new();
    int  cycles = 0;
    bit  quiet = 1'b0;     // No idling on either side once set.
    bit  hold_req = 1'b0;  // Asks the result side for one long hold-off.
    int  samples_sent = 0;
    int  cfg_writes = 0;

    spo2_baseline_percentile DUT (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_stall(o_in_stall),
        .i_raw_saturation(i_raw_saturation),
        .i_sample_valid(i_sample_valid),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_baseline_level(o_baseline_level),
        .o_usable_count(o_usable_count),
        .o_used_default(o_used_default),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data(i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // Result side. Words are sampled at the edge where they are taken, then
    // the stall for the next cycle is chosen: random bursts, one long
    // hold-off on request, and none in the quiet tail.
    initial begin : result_side
        int stall_left;
        t_baseline got;
        stall_left = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && !i_out_stall) begin
                got.level = o_baseline_level;
                got.count = o_usable_count;
                got.dflt = o_used_default;
                board.check_result(got);
            end
            if (hold_req) begin
                hold_req = 1'b0;
                stall_left = 600;
            end else if (stall_left == 0 && !quiet && $urandom_range(0, 9) == 0) begin
                stall_left = $urandom_range(1, 7);
            end
            if (quiet && stall_left < 100) stall_left = 0;
            if (stall_left > 0) begin
                i_out_stall <= 1'b1;
                stall_left--;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    // Offers one sample and holds it until taken. Valid stays high into the
    // next call unless a random gap follows.
    task automatic send_sample(input logic [RAW_W-1:0] raw, input logic ok);
        i_in_valid <= 1'b1;
        i_raw_saturation <= raw;
        i_sample_valid <= ok;
        do @(posedge i_clk); while (o_in_stall);
        board.note_sample(raw, ok);
        samples_sent++;
        if (!quiet && $urandom_range(0, 7) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
        end
    endtask

    // Mostly physiological samples near the usable band, some just outside,
    // and some anywhere in the 16-bit range.
    task automatic send_random(input int n);
        logic [RAW_W-1:0] raw;
        int pick;
        for (int k = 0; k < n; k++) begin
            pick = $urandom_range(0, 99);
            if (pick < 75) raw = RAW_W'($urandom_range(8600, 10000));
            else if (pick < 90) raw = RAW_W'($urandom_range(7900, 10100));
            else raw = RAW_W'($urandom);
            send_sample(raw, $urandom_range(0, 99) < 85);
        end
    endtask

    // Lets every owed baseline arrive and the last samples settle.
    task automatic drain();
        i_in_valid <= 1'b0;
        while (board.owed.size() != 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_I_W-1:0] idx, input logic [CFG_D_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        board.write_reg(idx, data);
        cfg_writes++;
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_epoch_window(input int spe, input int win);
        drain();
        write_reg(CFG_SAMPLES_PER_EPOCH, CFG_D_W'(spe));
        write_reg(CFG_WINDOW_SAMPLES, CFG_D_W'(win));
    endtask

    initial begin : stimulus
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed samples under the reset settings: band edges, just
        // outside them, field extremes, and a run of invalid samples so the
        // median sees no valid tap at all.
        send_sample(16'd8000, 1'b1);
        send_sample(16'd10000, 1'b1);
        send_sample(16'd7999, 1'b1);
        send_sample(16'd10001, 1'b1);
        send_sample(16'd0, 1'b1);
        send_sample(16'hFFFF, 1'b1);
        send_sample(16'hFFFF, 1'b0);
        repeat (5) send_sample(16'd9000, 1'b0);
        send_sample(16'd9500, 1'b1);
        send_sample(16'd9501, 1'b1);
        send_sample(16'd8000, 1'b0);
        send_sample(16'd9999, 1'b1);
        send_sample(16'd8001, 1'b1);
        for (int k = 0; k < 8; k++) send_sample(RAW_W'(9000 + 125 * k), 1'b1);
        send_random(65);

        // Epoch of one over a short window: a result for every sample.
        set_epoch_window(1, 12);
        send_random(200);

        // Zero registers are treated as one; unknown indexes change nothing.
        set_epoch_window(0, 0);
        write_reg(CFG_UNUSED_A, 11'h7FF);
        write_reg(CFG_UNUSED_B, 11'd5);
        send_random(40);

        // Oversized values saturate at the largest epoch and window.
        set_epoch_window(63, 2047);
        send_random(150);

        // Short epochs while the result side holds off for a long time.
        set_epoch_window(4, 20);
        send_random(30);
        hold_req = 1'b1;
        send_random(120);

        // Full-depth window with frequent epochs.
        set_epoch_window(10, 1024);
        send_random(100);

        // Shorter epoch written mid-epoch ends it at the next sample; the
        // sender also pauses until every baseline is back before each write.
        drain();
        write_reg(CFG_SAMPLES_PER_EPOCH, 11'd70);
        send_random(75);
        drain();
        write_reg(CFG_WINDOW_SAMPLES, 11'd40);
        write_reg(CFG_SAMPLES_PER_EPOCH, 11'd2);
        send_random(75);

        set_epoch_window(7, 100);
        send_random(100);

        // Tail with no idling on either side.
        set_epoch_window(32, 1023);
        quiet = 1'b1;
        send_random(70);
        drain();
        repeat (40) @(posedge i_clk);

        $display("Sent %0d samples and %0d register writes; checked %0d baselines.",
                 samples_sent, cfg_writes, board.checked);
        $display("Covered epoch and window extremes, invalid runs and output back-pressure.");
        if (board.errors == 0 && board.owed.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
